>>> rtl/core/rhc_pkg.sv
// rhc_pkg: shared types and constants for the RGB to HSV converter.
// Beat payloads, the queued job record and hue sector codes.
// No dependencies.
package rhc_pkg;

  // Input beat: one 8-bit RGB pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Result beat: HSV in fixed point, hue in 1/64 degree
  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } hsv_t;

  // Which channel holds the maximum (red wins ties, then green)
  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sect_t;

  // Classified pixel passed from front to back
  typedef struct packed {
    logic [7:0] bright;  // max channel
    logic [7:0] delta;   // max - min
    logic [7:0] absd;    // |signed channel difference|
    logic       neg;     // channel difference below zero
    sect_t      sect;
  } job_t;

  // Hue offsets in 1/64 degree
  localparam logic [14:0] HUE_GREEN_OFS = 15'd7680;
  localparam logic [14:0] HUE_BLUE_OFS  = 15'd15360;
  localparam logic [14:0] HUE_TURN      = 15'd23040;

  // Reciprocal table format: ceil(2^RECIP_SHIFT / d)
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  // Job queue between front and back (depth a power of two)
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

endpackage

>>> rtl/core/rgb_to_hsv_converter_core.sv
// Path: classifying front stage register, 4-entry job queue, then the 3-stage
// reciprocal-multiply back pipe ending in the result register. Throughput: one pixel
// per cycle while results are popped; full rises when back-pressure reaches the front.
// Reset (rst_n, synchronous, active low) empties all stages and the queue.
// Depends on rhc_pkg, rhc_front, rhc_queue, rhc_back.
module rgb_to_hsv_converter_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  rhc_pkg::rgb_t   in_data,
  output logic            empty,
  input  logic            pop,
  output rhc_pkg::hsv_t   out_data
);

  logic           f_valid, f_ready, q_valid, q_ready;
  rhc_pkg::job_t  f_job, q_job;

  // Front: accept and classify
  rhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  // Job queue
  rhc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_job   (f_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_job   (q_job)
  );

  // Back: divide pipe and result register
  rhc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/rhc_front.sv
// rhc_front: accepts pixels and classifies them (max, min, sector, difference).
// Depends on rhc_pkg.
module rhc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  rhc_pkg::rgb_t   in_data,
  output logic            job_valid,
  input  logic            job_ready,
  output rhc_pkg::job_t   job
);

  logic               v_r, v_nxt;
  rhc_pkg::job_t      job_r, job_nxt;
  logic               take;
  logic [7:0]         hi, lo;
  logic signed [8:0]  diff;

  // Stage register may load when empty or being drained
  assign full = v_r && !job_ready;
  assign take = push && !full;

  // Classification
  always_comb begin
    job_nxt = job_r;
    if (in_data.red >= in_data.green && in_data.red >= in_data.blue) begin
      hi           = in_data.red;
      job_nxt.sect = rhc_pkg::SECT_RED;
      diff         = $signed({1'b0, in_data.green}) - $signed({1'b0, in_data.blue});
    end else if (in_data.green >= in_data.blue) begin
      hi           = in_data.green;
      job_nxt.sect = rhc_pkg::SECT_GREEN;
      diff         = $signed({1'b0, in_data.blue}) - $signed({1'b0, in_data.red});
    end else begin
      hi           = in_data.blue;
      job_nxt.sect = rhc_pkg::SECT_BLUE;
      diff         = $signed({1'b0, in_data.red}) - $signed({1'b0, in_data.green});
    end
    lo = (in_data.red < in_data.green) ? in_data.red : in_data.green;
    if (in_data.blue < lo) begin
      lo = in_data.blue;
    end
    job_nxt.bright = hi;
    job_nxt.delta  = hi - lo;
    job_nxt.neg    = diff[8];
    job_nxt.absd   = diff[8] ? 8'(-diff) : diff[7:0];
  end

  // Valid tracking
  always_comb begin
    v_nxt = v_r;
    if (take) begin
      v_nxt = 1'b1;
    end else if (job_ready) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = v_r;
  assign job       = job_r;

`ifndef NO_ASSERTIONS
  // Difference never exceeds the spread of the pixel
  a_absd_le_delta: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> job_r.absd <= job_r.delta)
    else $error("front: |difference| above delta");
`endif

endmodule

>>> rtl/core/rhc_queue.sv
// rhc_queue: short job queue decoupling classification from the divide pipe.
// Depends on rhc_pkg.
module rhc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  rhc_pkg::job_t   wr_job,
  output logic            rd_valid,
  input  logic            rd_ready,
  output rhc_pkg::job_t   rd_job
);

  rhc_pkg::job_t              slot_r [rhc_pkg::Q_DEPTH];
  logic [rhc_pkg::Q_AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [rhc_pkg::Q_AW:0]     cnt_r, cnt_nxt;
  logic                       wr_en, rd_en;

  assign wr_ready = cnt_r != (rhc_pkg::Q_AW+1)'(rhc_pkg::Q_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_job   = slot_r[rp_r];

  // Pointer and fill count update
  always_comb begin
    wp_nxt  = wr_en ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd_en ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wp_r] <= wr_job;
    end
  end

`ifndef NO_ASSERTIONS
  // Fill count stays within depth and agrees with the pointers
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (rhc_pkg::Q_AW+1)'(rhc_pkg::Q_DEPTH))
    else $error("queue: fill count above depth");
  a_cnt_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[rhc_pkg::Q_AW-1:0] == rhc_pkg::Q_AW'(wp_r - rp_r))
    else $error("queue: count and pointers disagree");
`endif

endmodule

>>> rtl/core/rhc_back.sv
// rhc_back: reciprocal-multiply divide pipe producing hue and saturation,
// ending in the result register. Depends on rhc_pkg.
module rhc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  output logic            job_ready,
  input  rhc_pkg::job_t   job,
  output logic            empty,
  input  logic            pop,
  output rhc_pkg::hsv_t   out_data
);

  localparam int NS_W = 16;  // 255 * delta
  localparam int NH_W = 20;  // 3840 * |d|
  localparam int PS_W = NS_W + rhc_pkg::RECIP_W;
  localparam int PH_W = NH_W + rhc_pkg::RECIP_W;

  typedef struct packed {
    logic [NS_W-1:0]             num_s;
    logic [NH_W-1:0]             num_h;
    logic [rhc_pkg::RECIP_W-1:0] rcp_s;
    logic [rhc_pkg::RECIP_W-1:0] rcp_h;
    logic                        neg;
    rhc_pkg::sect_t              sect;
    logic [7:0]                  bright;
  } mul_in_t;

  typedef struct packed {
    logic [7:0]     sat;
    logic [11:0]    qh;
    logic           neg;
    rhc_pkg::sect_t sect;
    logic [7:0]     bright;
  } quot_t;

  logic [rhc_pkg::RECIP_W-1:0] recip_tab [256];

  logic           v1_r, v1_nxt, v2_r, v2_nxt, vo_r, vo_nxt;
  logic           rdy1, rdy2, rdyo;
  mul_in_t        s1_r, s1_nxt;
  quot_t          s2_r, s2_nxt;
  rhc_pkg::hsv_t  out_r, out_nxt;
  logic [PS_W-1:0] prod_s;
  logic [PH_W-1:0] prod_h;
  logic [14:0]    base;

  // Reciprocal table, ceil(2^28/d); entry 0 unused (numerator is 0 there)
  for (genvar i = 0; i < 256; i++) begin : g_recip
    localparam logic [rhc_pkg::RECIP_W-1:0] RECIP_VAL = (i == 0) ? '0 :
      rhc_pkg::RECIP_W'(((2 ** rhc_pkg::RECIP_SHIFT) + i - 1) / ((i == 0) ? 1 : i));
    assign recip_tab[i] = RECIP_VAL;
  end

  // Stage advance, bubbles collapse
  assign rdyo      = !vo_r || pop;
  assign rdy2      = !v2_r || rdyo;
  assign rdy1      = !v1_r || rdy2;
  assign job_ready = rdy1;

  // Stage 1: numerators and reciprocal lookup
  always_comb begin
    s1_nxt.num_s  = NS_W'(job.delta) * NS_W'(255);
    s1_nxt.num_h  = NH_W'(job.absd) * NH_W'(3840);
    s1_nxt.rcp_s  = recip_tab[job.bright];
    s1_nxt.rcp_h  = recip_tab[job.delta];
    s1_nxt.neg    = job.neg;
    s1_nxt.sect   = job.sect;
    s1_nxt.bright = job.bright;
  end

  // Stage 2: multiply by reciprocal, keep integer part
  always_comb begin
    prod_s        = PS_W'(s1_r.num_s) * PS_W'(s1_r.rcp_s);
    prod_h        = PH_W'(s1_r.num_h) * PH_W'(s1_r.rcp_h);
    s2_nxt.sat    = 8'(prod_s >> rhc_pkg::RECIP_SHIFT);
    s2_nxt.qh     = 12'(prod_h >> rhc_pkg::RECIP_SHIFT);
    s2_nxt.neg    = s1_r.neg;
    s2_nxt.sect   = s1_r.sect;
    s2_nxt.bright = s1_r.bright;
  end

  // Stage 3: sector offset and wrap of negative red hue
  always_comb begin
    case (s2_r.sect)
      rhc_pkg::SECT_RED:   base = s2_r.neg ? rhc_pkg::HUE_TURN : '0;
      rhc_pkg::SECT_GREEN: base = rhc_pkg::HUE_GREEN_OFS;
      rhc_pkg::SECT_BLUE:  base = rhc_pkg::HUE_BLUE_OFS;
      default:             base = '0;
    endcase
    out_nxt.hue        = s2_r.neg ? base - 15'(s2_r.qh) : base + 15'(s2_r.qh);
    out_nxt.saturation = s2_r.sat;
    out_nxt.brightness = s2_r.bright;
  end

  // Valid bits
  always_comb begin
    v1_nxt = rdy1 ? job_valid : v1_r;
    v2_nxt = rdy2 ? v1_r      : v2_r;
    vo_nxt = rdyo ? v2_r      : vo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      vo_r <= vo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && job_valid) begin
      s1_r <= s1_nxt;
    end
    if (rdy2 && v1_r) begin
      s2_r <= s2_nxt;
    end
    if (rdyo && v2_r) begin
      out_r <= out_nxt;
    end
  end

  assign empty    = !vo_r;
  assign out_data = out_r;

`ifndef NO_ASSERTIONS
  // Hue stays below a full turn
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> out_r.hue < rhc_pkg::HUE_TURN)
    else $error("back: hue out of range");
  // Black pixel gives zero hue and saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && out_r.brightness == '0) |-> (out_r.hue == '0 && out_r.saturation == '0))
    else $error("back: black pixel not zero");
`endif

endmodule

>>> verif/rgb_to_hsv_converter_core_test.sv
// rgb_to_hsv_converter_core_test: self-checking bench for the RGB to HSV core.
// Queued pixel driver, result monitor and an integer HSV predictor in one file.
// Depends on rhc_pkg and rgb_to_hsv_converter_core.
module rgb_to_hsv_converter_core_test;

  localparam int HUE_SIXTH   = 3840;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;
  localparam int N_RANDOM    = 530;

  // A pixel waiting to be offered; hold_off makes the driver wait for a drained core
  typedef struct {
    rhc_pkg::rgb_t px;
    bit            hold_off;
  } pix_job_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  rhc_pkg::rgb_t in_data = '0;
  logic full;
  logic empty;
  rhc_pkg::hsv_t out_data;

  pix_job_t      pending_px[$];
  rhc_pkg::hsv_t hsv_owed[$];
  int       pixels_in = 0;
  int       hsv_seen = 0;
  int       mismatches = 0;
  int       cycles = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  logic     rx_hold = 1'b0;  // long receiver hold-off
  logic     steady = 1'b0;   // stretches with no idling on either side

  rgb_to_hsv_converter_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Integer HSV of one pixel: red wins ties, then green
  function automatic rhc_pkg::hsv_t hsv_of(rhc_pkg::rgb_t px);
    int   r, g, b, hi, lo, span, ang, sat;
    rhc_pkg::hsv_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    hi = (r >= g) ? ((r >= b) ? r : b) : ((g >= b) ? g : b);
    lo = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
    span = hi - lo;
    sat = (hi != 0) ? (255 * span) / hi : 0;
    ang = 0;
    if (span != 0) begin
      if (hi == r) ang = (HUE_SIXTH * (g - b)) / span;
      else if (hi == g) ang = int'(rhc_pkg::HUE_GREEN_OFS) + (HUE_SIXTH * (b - r)) / span;
      else ang = int'(rhc_pkg::HUE_BLUE_OFS) + (HUE_SIXTH * (r - g)) / span;
      if (ang < 0) ang += int'(rhc_pkg::HUE_TURN);
    end
    res.hue = ang[14:0];
    res.saturation = sat[7:0];
    res.brightness = hi[7:0];
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int roll;
    if (steady || rx_hold) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic rhc_pkg::rgb_t mk_px(int r, int g, int b);
    rhc_pkg::rgb_t px;
    px.red = r[7:0];
    px.green = g[7:0];
    px.blue = b[7:0];
    return px;
  endfunction

  task automatic queue_px(rhc_pkg::rgb_t px, bit hold_off);
    pix_job_t job;
    job.px = px;
    job.hold_off = hold_off;
    pending_px = {pending_px, job};
  endtask

  // Random pixel: plain random, ties and greys, or channels pinned to the rails
  function automatic rhc_pkg::rgb_t rand_px();
    rhc_pkg::rgb_t px;
    int   roll, v;
    roll = $urandom_range(0, 99);
    px = rhc_pkg::rgb_t'(24'($urandom));
    if (roll >= 60 && roll < 70) begin
      v = $urandom_range(0, 255);
      px = mk_px(v, v, v);
    end else if (roll >= 70 && roll < 80) begin
      case ($urandom_range(0, 2))
        0: px.green = px.red;
        1: px.blue = px.green;
        default: px.blue = px.red;
      endcase
    end else if (roll >= 80) begin
      if ($urandom_range(0, 1)) px.red = $urandom_range(0, 1) ? 8'hff : 8'h00;
      if ($urandom_range(0, 1)) px.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
      if ($urandom_range(0, 1)) px.blue = $urandom_range(0, 1) ? 8'hff : 8'h00;
    end
    return px;
  endfunction

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, hsv_owed.size());
      $display("[rgb_to_hsv_converter_core] ERROR");
      $finish;
    end
  end

  // Driver: offer pending pixels, hold each until its beat is taken
  always @(posedge clk) begin
    logic taken;
    logic nxt_push;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      taken = push && !full;
      nxt_push = 1'b0;
      if (taken) begin
        hsv_owed = {hsv_owed, hsv_of(in_data)};
        pending_px.pop_front();
        pixels_in++;
        gap_left = idle_len();
      end
      if (push && !taken) begin
        nxt_push = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_px.size() > 0 &&
                   !(pending_px[0].hold_off && hsv_owed.size() != 0)) begin
        nxt_push = 1'b1;
        in_data <= pending_px[0].px;
      end
      push <= nxt_push;
    end
  end

  // Monitor: check each result beat against the oldest prediction
  always @(posedge clk) begin
    rhc_pkg::hsv_t want;
    logic nxt_pop;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        hsv_seen++;
        if (hsv_owed.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
          mismatches++;
        end else begin
          want = hsv_owed.pop_front();
          if (out_data.hue !== want.hue) begin
            $display("%0t: hue expected %0d got %0d", $time, want.hue, out_data.hue);
            mismatches++;
          end
          if (out_data.saturation !== want.saturation) begin
            $display("%0t: saturation expected %0d got %0d", $time,
                     want.saturation, out_data.saturation);
            mismatches++;
          end
          if (out_data.brightness !== want.brightness) begin
            $display("%0t: brightness expected %0d got %0d", $time,
                     want.brightness, out_data.brightness);
            mismatches++;
          end
        end
        stall_left = idle_len();
      end
      nxt_pop = 1'b0;
      if (rx_hold) nxt_pop = 1'b0;
      else if (stall_left > 0) stall_left--;
      else nxt_pop = 1'b1;
      pop <= nxt_pop;
    end
  end

  // Alternate between idling and steady stretches
  initial begin
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk);
      steady <= ~steady;
    end
  end

  // Long receiver hold-off once traffic is flowing, so the core backs up
  initial begin
    wait (pixels_in >= 40);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (80) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Stimulus, reset and end of run
  initial begin
    // directed: rails, every sector, ties, greys, wrap-around and unit deltas
    queue_px(mk_px(0, 0, 0), 1'b0);
    queue_px(mk_px(255, 255, 255), 1'b0);
    queue_px(mk_px(128, 128, 128), 1'b0);
    queue_px(mk_px(255, 0, 0), 1'b0);
    queue_px(mk_px(0, 255, 0), 1'b0);
    queue_px(mk_px(0, 0, 255), 1'b0);
    queue_px(mk_px(255, 255, 0), 1'b0);
    queue_px(mk_px(0, 255, 255), 1'b0);
    queue_px(mk_px(255, 0, 255), 1'b0);
    queue_px(mk_px(255, 0, 1), 1'b0);
    queue_px(mk_px(255, 0, 254), 1'b0);
    queue_px(mk_px(200, 255, 0), 1'b0);
    queue_px(mk_px(0, 100, 255), 1'b0);
    queue_px(mk_px(1, 0, 0), 1'b0);
    queue_px(mk_px(1, 1, 0), 1'b0);
    queue_px(mk_px(100, 101, 100), 1'b0);
    queue_px(mk_px(0, 1, 1), 1'b0);
    queue_px(mk_px(254, 255, 0), 1'b0);
    queue_px(mk_px(170, 85, 255), 1'b0);
    queue_px(mk_px(1, 2, 3), 1'b0);
    // random part, with two points where the sender waits for a drained core
    for (int i = 0; i < N_RANDOM; i++)
      queue_px(rand_px(), (i == 0) || (i == 300));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_px.size() != 0 || push) @(posedge clk);
    while (hsv_owed.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d pixels (rails, ties, greys, every sector, random) and",
             pixels_in);
    $display("checked %0d HSV results under random idling and a full-queue stall",
             hsv_seen);
    if (mismatches == 0) begin
      $display("[rgb_to_hsv_converter_core] OK");
    end else begin
      $display("[rgb_to_hsv_converter_core] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rhc_pkg.sv
rtl/core/rhc_front.sv
rtl/core/rhc_queue.sv
rtl/core/rhc_back.sv
rtl/core/rgb_to_hsv_converter_core.sv
verif/rgb_to_hsv_converter_core_test.sv
